// ----- rtl/assert_macros.svh -----
// Assertion helpers for the throttle block; clk and rst come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define A_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define A_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/lbrt_pkg.sv -----
package lbrt_pkg;

  localparam int RATE_W    = 34;
  localparam int TOTAL_W   = 48;
  localparam int TIME_W    = 32;
  localparam int FILL_W    = 32;
  localparam int MULT_W    = 16;
  localparam int SLOT_IN_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 34;

  // Drain product and saturation
  localparam int PROD_W = 63;
  localparam int HM_W   = 71;
  localparam int MAG_W  = 61;
  localparam logic [MAG_W-1:0] DRAIN_CAP = MAG_W'(1) << 60;
  localparam int LEN_W  = 62;

  // Burst factor of exactly 1.0 in Q8.8
  localparam logic [MULT_W-1:0] UNITY = 16'd256;

  // Decay divider
  localparam int NUMER_W    = RATE_W + MULT_W;
  localparam int DIV_CNT_W  = $clog2(NUMER_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_MULT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_SECS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAIN_MULT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BYTES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_BYTES = 3'd6;

  typedef struct packed {
    logic [RATE_W-1:0] initial_rate;
    logic [RATE_W-1:0] target_rate;
    logic [MULT_W-1:0] burst_multiplier;
    logic [MULT_W-1:0] decay_seconds;
    logic [MULT_W-1:0] drain_multiplier;
    logic [FILL_W-1:0] bucket_bytes;
    logic [FILL_W-1:0] restart_bytes;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic [FILL_W-1:0]  fill_level;
    logic [TOTAL_W-1:0] last_total;
    logic [TIME_W-1:0]  last_time;
    logic               throttle_flag;
    logic [RATE_W-1:0]  current_rate;
    logic [RATE_W-1:0]  start_rate;
    logic [TIME_W-1:0]  throttle_time;
    logic [RATE_W-1:0]  drain_rate;
  } entry_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic mul1;
    logic mul2;
    logic eval;
    logic dec;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
  } status_t;

endpackage

// ----- rtl/lbrt_div.sv -----
module lbrt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lbrt_pkg::NUMER_W-1:0]  numer,
  input  logic [lbrt_pkg::MULT_W-1:0]   denom,
  output logic                          busy,
  output logic [lbrt_pkg::NUMER_W-1:0]  quot
);

  logic [lbrt_pkg::MULT_W-1:0]    rem;
  logic [lbrt_pkg::DIV_CNT_W-1:0] cnt;
  logic [lbrt_pkg::MULT_W:0]      shifted;
  logic                           fits;

  // One quotient bit per cycle, restoring
  assign shifted = {rem, quot[lbrt_pkg::NUMER_W-1]};
  assign fits    = shifted >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= lbrt_pkg::DIV_CNT_W'(lbrt_pkg::NUMER_W);
      quot <= numer;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[lbrt_pkg::NUMER_W-2:0], fits};
      rem  <= fits ? lbrt_pkg::MULT_W'(shifted - {1'b0, denom})
                   : shifted[lbrt_pkg::MULT_W-1:0];
      cnt  <= cnt - 1'b1;
      if (cnt == lbrt_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/lbrt_dp.sv -----
module lbrt_dp #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  lbrt_pkg::cfg_t                  cfg,
  input  lbrt_pkg::cmd_t                  cmd,
  output lbrt_pkg::status_t               st,
  input  logic [lbrt_pkg::SLOT_IN_W-1:0]  client_slot,
  input  logic [lbrt_pkg::TOTAL_W-1:0]    byte_total,
  input  logic [lbrt_pkg::TIME_W-1:0]     now_seconds,
  output logic                            tracked,
  output logic                            is_throttled,
  output logic [lbrt_pkg::RATE_W-1:0]     granted_rate,
  output logic [lbrt_pkg::FILL_W-1:0]     fill_bytes
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EXT_W  = ((SLOT_W > lbrt_pkg::SLOT_IN_W) ? SLOT_W : lbrt_pkg::SLOT_IN_W) + 1;

  lbrt_pkg::entry_t mem [NUM_SLOTS];

  logic [SLOT_W-1:0]  clr_addr;
  logic [EXT_W-1:0]   slot_ext;

  logic [SLOT_W-1:0]              slot_idx;
  logic                           slot_oor;
  logic [lbrt_pkg::TOTAL_W-1:0]   tot;
  logic [lbrt_pkg::TIME_W-1:0]    now;
  lbrt_pkg::entry_t               ent;

  logic                           dt_neg;
  logic                           dt_zero;
  logic [lbrt_pkg::PROD_W-1:0]    prod;
  logic [lbrt_pkg::NUMER_W-1:0]   burst_prod;
  logic [lbrt_pkg::NUMER_W-1:0]   numer;
  logic [lbrt_pkg::HM_W-1:0]      hm;
  logic [lbrt_pkg::MULT_W-1:0]    lo;
  logic signed [lbrt_pkg::TOTAL_W:0] used;
  logic [lbrt_pkg::LEN_W-1:0]     len_c;

  lbrt_pkg::entry_t               upd;
  logic                           do_write;
  logic                           trk;
  logic                           need_div;

  // combinational helpers
  logic signed [lbrt_pkg::TIME_W:0] dt;
  logic [lbrt_pkg::TIME_W-1:0]      secs;
  logic signed [lbrt_pkg::TIME_W:0] elapsed;
  logic [lbrt_pkg::MULT_W-1:0]      e_clamp;
  logic [lbrt_pkg::RATE_W-1:0]      span;
  logic [lbrt_pkg::HM_W:0]          v_sum;
  logic [lbrt_pkg::MAG_W-1:0]       mag;
  logic signed [63:0]               delta;
  logic signed [63:0]               len_s;
  logic [lbrt_pkg::RATE_W-1:0]      init_rate;
  logic [lbrt_pkg::RATE_W-1:0]      burst_rate;
  logic [lbrt_pkg::LEN_W-1:0]       len_v;
  lbrt_pkg::entry_t                 upd_n;
  logic                             wr_n;
  logic                             trk_n;
  logic                             div_n;
  lbrt_pkg::entry_t                 fin_ent;
  logic                             mem_we;
  logic [SLOT_W-1:0]                mem_addr;
  lbrt_pkg::entry_t                 mem_wdata;
  logic                             div_busy;
  logic [lbrt_pkg::NUMER_W-1:0]     quot;

  assign slot_ext = EXT_W'(client_slot);
  assign init_rate = (cfg.initial_rate > cfg.target_rate) ? cfg.initial_rate
                                                           : cfg.target_rate;

  assign st.clr_done = (clr_addr == SLOT_W'(NUM_SLOTS - 1));
  assign st.div_busy = div_busy;

  lbrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.dec & div_n),
    .numer (numer),
    .denom (cfg.decay_seconds),
    .busy  (div_busy),
    .quot  (quot)
  );

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // table: one write port, registered read at accept
  assign mem_we    = cmd.clear_wr | (cmd.fin & do_write);
  assign mem_addr  = cmd.clear_wr ? clr_addr : slot_idx;
  assign mem_wdata = cmd.clear_wr ? '0 : fin_ent;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.accept) begin
      ent <= mem[slot_ext[SLOT_W-1:0]];
    end
  end

  always_comb begin
    dt      = $signed({1'b0, now}) - $signed({1'b0, ent.last_time});
    secs    = dt[lbrt_pkg::TIME_W] ? lbrt_pkg::TIME_W'(-dt) : dt[lbrt_pkg::TIME_W-1:0];
    elapsed = $signed({1'b0, now}) - $signed({1'b0, ent.throttle_time});
    if (elapsed[lbrt_pkg::TIME_W]) begin
      e_clamp = '0;
    end else if (elapsed > $signed({17'b0, cfg.decay_seconds})) begin
      e_clamp = cfg.decay_seconds;
    end else begin
      e_clamp = elapsed[lbrt_pkg::MULT_W-1:0];
    end
    span = (ent.start_rate > cfg.target_rate) ? ent.start_rate - cfg.target_rate : '0;
  end

  always_comb begin
    v_sum = (lbrt_pkg::HM_W+1)'(hm) + (lbrt_pkg::HM_W+1)'(lo);
    if (hm > lbrt_pkg::HM_W'(lbrt_pkg::DRAIN_CAP) ||
        v_sum > (lbrt_pkg::HM_W+1)'(lbrt_pkg::DRAIN_CAP)) begin
      mag = lbrt_pkg::DRAIN_CAP;
    end else begin
      mag = v_sum[lbrt_pkg::MAG_W-1:0];
    end
    delta = dt_neg ? -$signed({3'b0, mag}) : $signed({3'b0, mag});
    len_s = 64'(used) - delta + $signed({32'b0, ent.fill_level});
  end

  // pipeline of the per-sample arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_idx <= slot_ext[SLOT_W-1:0];
      slot_oor <= slot_ext >= EXT_W'(NUM_SLOTS);
      tot      <= byte_total;
      now      <= now_seconds;
    end
    if (cmd.mul1) begin
      dt_neg     <= dt[lbrt_pkg::TIME_W];
      dt_zero    <= (dt == '0);
      prod       <= ent.drain_rate[lbrt_pkg::RATE_W-1:3] * secs;
      burst_prod <= cfg.target_rate * cfg.burst_multiplier;
      numer      <= span * (cfg.decay_seconds - e_clamp);
    end
    if (cmd.mul2) begin
      hm   <= prod[lbrt_pkg::PROD_W-1:8] * cfg.drain_multiplier;
      lo   <= lbrt_pkg::MULT_W'((24'(prod[7:0]) * cfg.drain_multiplier) >> 8);
      used <= $signed({1'b0, tot}) - $signed({1'b0, ent.last_total});
    end
    if (cmd.eval) begin
      len_c <= len_s[63] ? '0 : len_s[lbrt_pkg::LEN_W-1:0];
    end
    if (cmd.dec) begin
      upd      <= upd_n;
      do_write <= wr_n;
      trk      <= trk_n;
      need_div <= div_n;
    end
  end

  always_comb begin
    burst_rate = (|burst_prod[lbrt_pkg::NUMER_W-1:42]) ? '1 : burst_prod[41:8];
    if (cfg.burst_multiplier <= lbrt_pkg::UNITY) begin
      burst_rate = cfg.target_rate;
    end
  end

  // bucket update and throttle decision
  always_comb begin
    upd_n = ent;
    wr_n  = 1'b0;
    trk_n = 1'b0;
    div_n = 1'b0;
    len_v = len_c;
    if (!slot_oor) begin
      if (!ent.valid) begin
        if (cfg.bucket_bytes != '0) begin
          upd_n.valid         = 1'b1;
          upd_n.fill_level    = '0;
          upd_n.last_total    = tot;
          upd_n.last_time     = now;
          upd_n.throttle_flag = 1'b0;
          upd_n.current_rate  = init_rate;
          upd_n.start_rate    = '0;
          upd_n.throttle_time = '0;
          upd_n.drain_rate    = cfg.target_rate;
          wr_n  = 1'b1;
          trk_n = 1'b1;
        end
      end else if (cfg.bucket_bytes == '0) begin
        upd_n.throttle_flag = 1'b0;
        upd_n.current_rate  = init_rate;
        wr_n  = 1'b1;
        trk_n = 1'b1;
      end else begin
        wr_n  = 1'b1;
        trk_n = 1'b1;
        upd_n.last_time  = now;
        upd_n.last_total = tot;
        if (!dt_zero) begin
          upd_n.drain_rate = cfg.target_rate;
          if (len_c <= lbrt_pkg::LEN_W'(cfg.restart_bytes)) begin
            upd_n.throttle_flag = 1'b0;
            upd_n.current_rate  = init_rate;
          end else if (len_c >= lbrt_pkg::LEN_W'(cfg.bucket_bytes) || ent.throttle_flag) begin
            if (len_c > lbrt_pkg::LEN_W'(cfg.bucket_bytes)) begin
              len_v = lbrt_pkg::LEN_W'(cfg.bucket_bytes);
            end
            if (!ent.throttle_flag) begin
              upd_n.start_rate    = burst_rate;
              upd_n.current_rate  = burst_rate;
              upd_n.throttle_time = now;
            end else if (ent.current_rate > cfg.target_rate) begin
              if (cfg.decay_seconds != '0) begin
                div_n = 1'b1;
              end else begin
                upd_n.current_rate = cfg.target_rate;
              end
            end
            if (upd_n.current_rate < cfg.target_rate) begin
              upd_n.current_rate = cfg.target_rate;
            end
            upd_n.throttle_flag = 1'b1;
          end
          upd_n.fill_level = len_v[lbrt_pkg::FILL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    fin_ent = upd;
    if (need_div) begin
      fin_ent.current_rate = cfg.target_rate + quot[lbrt_pkg::RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      tracked      <= trk;
      is_throttled <= trk & fin_ent.throttle_flag;
      granted_rate <= !trk ? '0 : (fin_ent.throttle_flag ? fin_ent.current_rate : init_rate);
      fill_bytes   <= trk ? fin_ent.fill_level : '0;
    end
  end

endmodule

// ----- rtl/lbrt_ctrl.sv -----
module lbrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  input  lbrt_pkg::status_t   st,
  output lbrt_pkg::cmd_t      cmd,
  output logic                in_ready,
  output logic                out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_EVAL, S_DEC, S_DIV, S_FIN
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  assign cmd.clear_wr = (state == S_CLEAR);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.mul1     = (state == S_MUL1);
  assign cmd.mul2     = (state == S_MUL2);
  assign cmd.eval     = (state == S_EVAL);
  assign cmd.dec      = (state == S_DEC);
  assign cmd.fin      = (state == S_FIN) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: if (st.clr_done) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_EVAL;
        S_EVAL:  state <= S_DEC;
        S_DEC:   state <= S_DIV;
        // hold until the decay divide finishes
        S_DIV:   if (!st.div_busy) state <= S_FIN;
        S_FIN:   if (slot_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/leaky_bucket_rate_throttle.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_ready    client_slot, byte_total, now_seconds
// out      out_valid / out_ready  tracked, is_throttled, granted_rate, fill_bytes
// cfg      cfg_write              cfg_index, cfg_data
//
// One word at a time, through S_MUL1, S_MUL2, S_EVAL, S_DEC, S_DIV (held while a
// decaying rate runs the one-bit-per-cycle divider, 50 quotient bits) and S_FIN
// (held until the output register is free); out_valid rises and in_ready returns
// together as S_FIN ends. After reset the slot table is swept clear, in_ready low.
// A finished result waits in the output register; a new word is taken meanwhile.
`include "assert_macros.svh"

module leaky_bucket_rate_throttle #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lbrt_pkg::SLOT_IN_W-1:0]   client_slot,
  input  logic [lbrt_pkg::TOTAL_W-1:0]     byte_total,
  input  logic [lbrt_pkg::TIME_W-1:0]      now_seconds,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             tracked,
  output logic                             is_throttled,
  output logic [lbrt_pkg::RATE_W-1:0]      granted_rate,
  output logic [lbrt_pkg::FILL_W-1:0]      fill_bytes,
  input  logic                             cfg_write,
  input  logic [lbrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbrt_pkg::CFG_DAT_W-1:0]   cfg_data
);

  lbrt_pkg::cfg_t    cfg;
  lbrt_pkg::cmd_t    cmd;
  lbrt_pkg::status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_rate     <= '0;
      cfg.target_rate      <= '0;
      cfg.burst_multiplier <= lbrt_pkg::UNITY;
      cfg.decay_seconds    <= '0;
      cfg.drain_multiplier <= lbrt_pkg::UNITY;
      cfg.bucket_bytes     <= '0;
      cfg.restart_bytes    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lbrt_pkg::REG_INITIAL_RATE:  cfg.initial_rate     <= cfg_data;
        lbrt_pkg::REG_TARGET_RATE:   cfg.target_rate      <= cfg_data;
        lbrt_pkg::REG_BURST_MULT:    cfg.burst_multiplier <= cfg_data[lbrt_pkg::MULT_W-1:0];
        lbrt_pkg::REG_DECAY_SECS:    cfg.decay_seconds    <= cfg_data[lbrt_pkg::MULT_W-1:0];
        lbrt_pkg::REG_DRAIN_MULT:    cfg.drain_multiplier <= cfg_data[lbrt_pkg::MULT_W-1:0];
        lbrt_pkg::REG_BUCKET_BYTES:  cfg.bucket_bytes     <= cfg_data[lbrt_pkg::FILL_W-1:0];
        lbrt_pkg::REG_RESTART_BYTES: cfg.restart_bytes    <= cfg_data[lbrt_pkg::FILL_W-1:0];
        default: ;
      endcase
    end
  end

  lbrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  lbrt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .st           (st),
    .client_slot  (client_slot),
    .byte_total   (byte_total),
    .now_seconds  (now_seconds),
    .tracked      (tracked),
    .is_throttled (is_throttled),
    .granted_rate (granted_rate),
    .fill_bytes   (fill_bytes)
  );

  `A_IMPLY(a_no_accept_in_clear, cmd.clear_wr, !in_ready)
  `A_IMPLY(a_fin_slot_free, cmd.fin, !out_valid || out_ready)
  `A_NEXT(a_one_word_in_flight, cmd.accept, !in_ready)
  `A_NEXT(a_fin_raises_valid, cmd.fin, out_valid)

endmodule
